/* design/lsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types and constants of the load/store core with its window cache.
// ----------------------------------------------------------------------------
package lsc_pkg;

  localparam int unsigned DATA_DEPTH     = 32;
  localparam int unsigned WINDOW_ENTRIES = 8;
  localparam int unsigned REG_COUNT      = 16;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned INSTR_W = 16;
  localparam int unsigned ADDR_W = $clog2(DATA_DEPTH);
  localparam int unsigned WIN_IDX_W = $clog2(WINDOW_ENTRIES);
  localparam int unsigned REG_IDX_W = $clog2(REG_COUNT);

  // window placement around the missed address
  localparam int unsigned WIN_LO  = (WINDOW_ENTRIES - 1) / 2;
  localparam int unsigned WIN_HI  = WINDOW_ENTRIES / 2;
  localparam int unsigned WIN_TOP =
      (DATA_DEPTH >= WINDOW_ENTRIES) ? DATA_DEPTH - WINDOW_ENTRIES : 0;

  // stream packing
  localparam int unsigned IN_FIELDS_W = INSTR_W + ADDR_W + WORD_W;
  localparam int unsigned IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = WORD_W;
  localparam int unsigned OUT_TUSER_W = 2;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_EXEC  = 2'd2,
    OP_READ  = 2'd3
  } lsc_op_e;

  typedef enum logic [1:0] {
    INS_LOAD  = 2'd0,
    INS_STORE = 2'd1,
    INS_ADD   = 2'd2,
    INS_SUB   = 2'd3
  } lsc_ins_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_READ_B,
    S_EXEC,
    S_READ_DM,
    S_FILL,
    S_FILL_LAST,
    S_WB,
    S_DONE
  } lsc_state_e;

endpackage

/* design/load_store_core_with_window_cache.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_store_core_with_window_cache
// Small load/store core with a register file, a data memory and a window cache.
// ----------------------------------------------------------------------------
// One beat in, one beat out. The core takes a beat only when idle, then runs it
// through a short sequencer around one shared adder/subtractor, a register file
// with one read port and a single-read-port data memory. Start and a miss refill
// the window by walking WINDOW_ENTRIES words through the data memory read port,
// one word a cycle, then drain the last read in S_FILL_LAST. A finished result
// sits in the output register while the next beat is accepted.
module load_store_core_with_window_cache (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // instruction [15:0], mem_address [20:16], mem_data [52:21], zero pad
  input  logic [lsc_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // operation [1:0]
  input  logic [lsc_pkg::IN_TUSER_W-1:0]  s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // result_value [31:0]
  output logic [lsc_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // cache_hit [0], window_refilled [1]
  output logic [lsc_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o
);

  import lsc_pkg::*;

  lsc_state_e state_q, state_d;

  // latched beat
  lsc_op_e              op_q;
  logic [INSTR_W-1:0]   instr_q;
  logic [ADDR_W-1:0]    haddr_q;
  logic [WORD_W-1:0]    hdata_q;

  lsc_ins_e             ins_type;
  logic [REG_IDX_W-1:0] ra, rb, rd;
  logic [ADDR_W-1:0]    maddr;

  // register file
  logic [WORD_W-1:0]    rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0] rf_valid_q;
  logic [WORD_W-1:0]    rf_rdata_q;
  logic                 rf_rvld_q;
  logic [WORD_W-1:0]    rf_rword;
  logic [REG_IDX_W-1:0] rf_raddr, rf_waddr;
  logic                 rf_we, rf_clr;
  logic [WORD_W-1:0]    rf_wdata;

  // data memory
  logic [WORD_W-1:0]     dm_mem [DATA_DEPTH];
  logic [DATA_DEPTH-1:0] dm_valid_q;
  logic [WORD_W-1:0]     dm_rdata_q;
  logic                  dm_rvld_q;
  logic [WORD_W-1:0]     dm_rword;
  logic [ADDR_W-1:0]     dm_raddr;
  logic                  dm_we;
  logic [WORD_W-1:0]     dm_wdata;

  // window cache
  logic [ADDR_W-1:0]         win_tag_q  [WINDOW_ENTRIES];
  logic [WORD_W-1:0]         win_word_q [WINDOW_ENTRIES];
  logic [WINDOW_ENTRIES-1:0] win_valid_q;
  logic [ADDR_W-1:0]         lk_addr;
  logic                      lk_found;
  logic [WIN_IDX_W-1:0]      lk_idx;
  logic                      win_inval;
  logic [ADDR_W-1:0]         first_calc;

  // refill walk
  logic [ADDR_W-1:0]    first_q;
  logic [WIN_IDX_W-1:0] cnt_q;
  logic                 pend_q;
  logic [WIN_IDX_W-1:0] pend_idx_q;
  logic [ADDR_W-1:0]    pend_tag_q;
  logic                 pend_in_q;
  logic [ADDR_W:0]      fill_addr;
  logic                 fill_in;
  logic                 fill_issue;

  // shared adder/subtractor
  logic [WORD_W-1:0] alu_a, alu_b, alu_y;
  logic              alu_sub;

  // result
  logic [WORD_W-1:0] op_a_q;
  logic [WORD_W-1:0] load_val_q;
  logic [WORD_W-1:0] res_value_q;
  logic              res_hit_q, res_refill_q;
  logic              out_load;
  logic              m_tvalid_q;
  logic [WORD_W-1:0] m_tdata_q;
  logic [OUT_TUSER_W-1:0] m_tuser_q;

  logic in_accept;

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);

  assign ins_type = lsc_ins_e'(instr_q[15:14]);
  assign ra       = instr_q[13:10];
  assign rb       = instr_q[9:6];
  assign rd       = instr_q[3:0];
  assign maddr    = instr_q[ADDR_W-1:0];

  assign rf_rword = rf_rvld_q ? rf_rdata_q : '0;
  assign dm_rword = dm_rvld_q ? dm_rdata_q : '0;

  // shared unit
  assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  assign fill_addr = alu_y[ADDR_W:0];
  assign fill_in   = (fill_addr < (ADDR_W + 1)'(DATA_DEPTH));

  // window lookup, lowest matching entry wins
  assign lk_addr = (op_q == OP_EXEC) ? maddr : haddr_q;

  always_comb begin
    lk_found = 1'b0;
    lk_idx   = '0;
    for (int i = WINDOW_ENTRIES - 1; i >= 0; i--) begin
      if (win_tag_q[i] == lk_addr) begin
        lk_found = 1'b1;
        lk_idx   = WIN_IDX_W'(i);
      end
    end
  end

  always_comb begin
    logic [ADDR_W:0] la;
    la = {1'b0, lk_addr};
    if (la < (ADDR_W + 1)'(WIN_LO)) begin
      first_calc = '0;
    end else if (la + (ADDR_W + 1)'(WIN_HI) > (ADDR_W + 1)'(DATA_DEPTH - 1)) begin
      first_calc = ADDR_W'(WIN_TOP);
    end else begin
      first_calc = ADDR_W'(la - (ADDR_W + 1)'(WIN_LO));
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) state_d = S_DECODE;
      end
      S_DECODE: begin
        unique case (op_q)
          OP_WRITE: state_d = S_DONE;
          OP_START: state_d = S_FILL;
          OP_READ:  state_d = S_READ_DM;
          OP_EXEC: begin
            if (ins_type == INS_LOAD) begin
              state_d = (lk_found && win_valid_q[lk_idx]) ? S_WB : S_FILL;
            end else begin
              state_d = S_READ_B;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_READ_B: begin
        state_d = (ins_type == INS_STORE) ? S_DONE : S_EXEC;
      end
      S_EXEC:    state_d = S_DONE;
      S_READ_DM: state_d = S_DONE;
      S_FILL: begin
        if (cnt_q == WIN_IDX_W'(WINDOW_ENTRIES - 1)) state_d = S_FILL_LAST;
      end
      S_FILL_LAST: begin
        state_d = (op_q == OP_START) ? S_DONE : S_WB;
      end
      S_WB: state_d = S_DONE;
      S_DONE: begin
        if (!m_tvalid_q || m_axis_tready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    rf_raddr   = ra;
    rf_we      = 1'b0;
    rf_waddr   = rd;
    rf_wdata   = alu_y;
    rf_clr     = 1'b0;
    dm_raddr   = haddr_q;
    dm_we      = 1'b0;
    dm_wdata   = hdata_q;
    win_inval  = 1'b0;
    fill_issue = 1'b0;
    alu_a      = WORD_W'(first_q);
    alu_b      = WORD_W'(cnt_q);
    alu_sub    = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      S_DECODE: begin
        if (op_q == OP_WRITE) begin
          dm_we     = 1'b1;
          win_inval = lk_found;
        end
        if (op_q == OP_START) rf_clr = 1'b1;
      end
      S_READ_B: begin
        rf_raddr = rb;
        if (ins_type == INS_STORE) begin
          dm_we     = 1'b1;
          dm_wdata  = rf_rword;
          win_inval = lk_found;
        end
      end
      S_EXEC: begin
        alu_a   = op_a_q;
        alu_b   = rf_rword;
        alu_sub = (ins_type == INS_SUB);
        rf_we   = 1'b1;
      end
      S_FILL: begin
        fill_issue = 1'b1;
        dm_raddr   = fill_addr[ADDR_W-1:0];
      end
      S_WB: begin
        rf_we    = 1'b1;
        rf_waddr = ra;
        rf_wdata = load_val_q;
      end
      S_DONE: begin
        out_load = !m_tvalid_q || m_axis_tready_i;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rf_valid_q  <= '0;
      dm_valid_q  <= '0;
      win_valid_q <= '0;
      for (int i = 0; i < WINDOW_ENTRIES; i++) win_tag_q[i] <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      m_tvalid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (rf_clr) rf_valid_q <= '0;
      else if (rf_we) rf_valid_q[rf_waddr] <= 1'b1;
      if (dm_we) dm_valid_q[lk_addr] <= 1'b1;
      if (win_inval) win_valid_q[lk_idx] <= 1'b0;
      if (pend_q) begin
        win_tag_q[pend_idx_q]   <= pend_tag_q;
        win_valid_q[pend_idx_q] <= pend_in_q;
      end
      if (state_q == S_DECODE) cnt_q <= '0;
      else if (fill_issue) cnt_q <= cnt_q + 1'b1;
      pend_q <= fill_issue;
      if (out_load) m_tvalid_q <= 1'b1;
      else if (m_axis_tready_i) m_tvalid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q    <= lsc_op_e'(s_axis_tuser_i[1:0]);
      instr_q <= s_axis_tdata_i[INSTR_W-1:0];
      haddr_q <= s_axis_tdata_i[INSTR_W +: ADDR_W];
      hdata_q <= s_axis_tdata_i[INSTR_W + ADDR_W +: WORD_W];
      res_value_q  <= '0;
      res_hit_q    <= 1'b0;
      res_refill_q <= 1'b0;
    end
    if (state_q == S_DECODE) begin
      first_q <= (op_q == OP_START) ? '0 : first_calc;
      if (op_q == OP_WRITE) res_value_q <= hdata_q;
      if (op_q == OP_START) res_refill_q <= 1'b1;
      if (op_q == OP_EXEC && ins_type == INS_LOAD) begin
        if (lk_found && win_valid_q[lk_idx]) begin
          load_val_q <= win_word_q[lk_idx];
          res_hit_q  <= 1'b1;
        end else begin
          res_refill_q <= 1'b1;
        end
      end
    end
    if (state_q == S_READ_B) begin
      op_a_q <= rf_rword;
      if (ins_type == INS_STORE) res_value_q <= rf_rword;
    end
    if (state_q == S_EXEC) res_value_q <= alu_y;
    if (state_q == S_READ_DM) res_value_q <= dm_rword;
    if (state_q == S_WB) res_value_q <= load_val_q;
    if (fill_issue) begin
      pend_idx_q <= cnt_q;
      pend_tag_q <= fill_addr[ADDR_W-1:0];
      pend_in_q  <= fill_in;
    end
    if (pend_q) begin
      win_word_q[pend_idx_q] <= pend_in_q ? dm_rword : '0;
      if (pend_in_q && pend_tag_q == maddr) load_val_q <= dm_rword;
    end
    if (out_load) begin
      m_tdata_q <= res_value_q;
      m_tuser_q <= {res_refill_q, res_hit_q};
    end
  end

  // register file and data memory
  always_ff @(posedge clk_i) begin
    if (rf_we) rf_mem[rf_waddr] <= rf_wdata;
    rf_rdata_q <= rf_mem[rf_raddr];
    rf_rvld_q  <= rf_valid_q[rf_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (dm_we) dm_mem[lk_addr] <= dm_wdata;
    dm_rdata_q <= dm_mem[dm_raddr];
    dm_rvld_q  <= dm_valid_q[dm_raddr];
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;
  assign m_axis_tuser_o  = m_tuser_q;

  a_fill_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL && cnt_q == WIN_IDX_W'(WINDOW_ENTRIES - 1))
      |=> (state_q == S_FILL_LAST))
    else $error("refill walk did not end after the last entry");

  a_fill_no_inval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pend_q && win_inval))
    else $error("window refill and invalidate in the same cycle");

  a_miss_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB && !res_hit_q) |-> (lk_found && win_valid_q[lk_idx]))
    else $error("refilled window does not hold the missed address");

  a_hit_no_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> !(res_hit_q && res_refill_q))
    else $error("beat flagged as both hit and refill");

  a_rf_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rf_we && rf_clr))
    else $error("register write during register clear");

endmodule

/* test/lsc_result_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_result_check
// Watches both stream channels of the load/store core. Every beat taken in is
// run through a local copy of the registers, the data memory and the window
// cache. The result beats that come out are compared field by field, in order.
// ----------------------------------------------------------------------------
module lsc_result_check (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [lsc_pkg::IN_TDATA_W-1:0]  in_data_i,
  input  logic [lsc_pkg::IN_TUSER_W-1:0]  in_user_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [lsc_pkg::OUT_TDATA_W-1:0] out_data_i,
  input  logic [lsc_pkg::OUT_TUSER_W-1:0] out_user_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import lsc_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              hit;
    logic              refilled;
  } core_result_t;

  logic [WORD_W-1:0] regs     [REG_COUNT];
  logic [WORD_W-1:0] mem      [DATA_DEPTH];
  logic [ADDR_W-1:0] win_tag  [WINDOW_ENTRIES];
  logic [WORD_W-1:0] win_word [WINDOW_ENTRIES];
  logic              win_vld  [WINDOW_ENTRIES];

  core_result_t results_in_flight [$];
  int           fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = results_in_flight.size();

  function automatic void window_load(input int unsigned centre);
    int lo;
    int unsigned a;
    lo = int'(centre) - int'(WIN_LO);
    if (lo < 0) begin
      lo = 0;
    end else if (int'(centre) + int'(WIN_HI) > int'(DATA_DEPTH) - 1) begin
      lo = int'(WIN_TOP);
    end
    for (int i = 0; i < WINDOW_ENTRIES; i++) begin
      a = lo + i;
      win_tag[i] = a[ADDR_W-1:0];
      if (a < DATA_DEPTH) begin
        win_word[i] = mem[a];
        win_vld[i]  = 1'b1;
      end else begin
        win_word[i] = '0;
        win_vld[i]  = 1'b0;
      end
    end
  endfunction

  // first entry with a matching tag decides, valid or not
  function automatic int window_lookup(input int unsigned a);
    for (int i = 0; i < WINDOW_ENTRIES; i++) begin
      if (win_tag[i] == a) return i;
    end
    return -1;
  endfunction

  function automatic void mem_store(input int unsigned a, input logic [WORD_W-1:0] v);
    int e;
    e = window_lookup(a);
    mem[a] = v;
    if (e >= 0) win_vld[e] = 1'b0;
  endfunction

  function automatic core_result_t core_step(input lsc_op_e op,
                                             input logic [INSTR_W-1:0] ins,
                                             input logic [ADDR_W-1:0] haddr,
                                             input logic [WORD_W-1:0] hdata);
    core_result_t r;
    int unsigned  ha;
    int unsigned  ma;
    int           e;
    lsc_ins_e     kind;
    logic [3:0]   ra;
    logic [3:0]   rb;
    logic [3:0]   rd;
    r    = '0;
    ha   = haddr % DATA_DEPTH;
    ma   = ins[7:0] % DATA_DEPTH;
    kind = lsc_ins_e'(ins[15:14]);
    ra   = ins[13:10];
    rb   = ins[9:6];
    rd   = ins[3:0];
    case (op)
      OP_WRITE: begin
        mem_store(ha, hdata);
        r.value = hdata;
      end
      OP_START: begin
        for (int i = 0; i < REG_COUNT; i++) regs[i] = '0;
        window_load(0);
        r.refilled = 1'b1;
      end
      OP_READ: begin
        r.value = mem[ha];
      end
      OP_EXEC: begin
        case (kind)
          INS_ADD: begin
            r.value  = regs[ra] + regs[rb];
            regs[rd] = r.value;
          end
          INS_SUB: begin
            r.value  = regs[ra] - regs[rb];
            regs[rd] = r.value;
          end
          INS_LOAD: begin
            e = window_lookup(ma);
            if (e >= 0 && win_vld[e]) begin
              r.value = win_word[e];
              r.hit   = 1'b1;
            end else begin
              window_load(ma);
              r.refilled = 1'b1;
              r.value    = mem[ma];
            end
            regs[ra] = r.value;
          end
          INS_STORE: begin
            r.value = regs[ra];
            mem_store(ma, r.value);
          end
        endcase
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    core_result_t want;
    core_result_t got;
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) regs[i] = '0;
      for (int i = 0; i < DATA_DEPTH; i++) mem[i] = '0;
      for (int i = 0; i < WINDOW_ENTRIES; i++) begin
        win_tag[i]  = '0;
        win_word[i] = '0;
        win_vld[i]  = 1'b0;
      end
      results_in_flight.delete();
      fail_count = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.value    = out_data_i[WORD_W-1:0];
        got.hit      = out_user_i[0];
        got.refilled = out_user_i[1];
        if (results_in_flight.size() == 0) begin
          $display("%0t: result beat with none outstanding, got value %h hit %b refilled %b",
                   $time, got.value, got.hit, got.refilled);
          fail_count++;
        end else begin
          want = results_in_flight.pop_front();
          if (got.value !== want.value) begin
            $display("%0t: result_value expected %h, got %h", $time, want.value, got.value);
            fail_count++;
          end
          if (got.hit !== want.hit) begin
            $display("%0t: cache_hit expected %b, got %b", $time, want.hit, got.hit);
            fail_count++;
          end
          if (got.refilled !== want.refilled) begin
            $display("%0t: window_refilled expected %b, got %b", $time, want.refilled,
                     got.refilled);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        results_in_flight.push_back(core_step(lsc_op_e'(in_user_i),
                                              in_data_i[INSTR_W-1:0],
                                              in_data_i[INSTR_W +: ADDR_W],
                                              in_data_i[INSTR_W + ADDR_W +: WORD_W]));
      end
    end
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the load/store core with directed host operations and instructions
// around the window edges, then a long random mix, with random stalls on both
// streams. Results are checked by lsc_result_check.
// ----------------------------------------------------------------------------
module tb_top;
  import lsc_pkg::*;

  logic                   clk_i    = 1'b0;
  logic                   rst_ni   = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic [IN_TUSER_W-1:0]  s_tuser  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;
  logic                   steady   = 1'b0;
  int                     fail_count;
  int                     pending;

  always #5 clk_i = ~clk_i;

  load_store_core_with_window_cache u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  lsc_result_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_tvalid),
    .in_ready_i   (s_tready),
    .in_data_i    (s_tdata),
    .in_user_i    (s_tuser),
    .out_valid_i  (m_tvalid),
    .out_ready_i  (m_tready),
    .out_data_i   (m_tdata),
    .out_user_i   (m_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    if (steady) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= 12);
    end
  end

  function automatic logic [INSTR_W-1:0] mem_ins(input lsc_ins_e kind, input logic [3:0] ra,
                                                 input logic [7:0] a);
    logic [1:0] spare;
    spare = 2'($urandom_range(0, 3));
    return {kind, ra, spare, a};
  endfunction

  function automatic logic [INSTR_W-1:0] alu_ins(input lsc_ins_e kind, input logic [3:0] ra,
                                                 input logic [3:0] rb, input logic [3:0] rd);
    logic [1:0] spare;
    spare = 2'($urandom_range(0, 3));
    return {kind, ra, rb, spare, rd};
  endfunction

  task automatic send_beat(input lsc_op_e op, input logic [INSTR_W-1:0] ins,
                           input logic [ADDR_W-1:0] addr, input logic [WORD_W-1:0] data);
    if (!steady) begin
      while ($urandom_range(0, 99) < 12) begin
        s_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= IN_TDATA_W'({data, addr, ins});
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic host_write(input logic [ADDR_W-1:0] addr, input logic [WORD_W-1:0] data);
    send_beat(OP_WRITE, INSTR_W'($urandom_range(0, 65535)), addr, data);
  endtask

  task automatic host_read(input logic [ADDR_W-1:0] addr);
    send_beat(OP_READ, INSTR_W'($urandom_range(0, 65535)), addr, $urandom);
  endtask

  task automatic run_start();
    send_beat(OP_START, INSTR_W'($urandom_range(0, 65535)), ADDR_W'($urandom_range(0, 31)),
              $urandom);
  endtask

  task automatic run_ins(input logic [INSTR_W-1:0] ins);
    send_beat(OP_EXEC, ins, ADDR_W'($urandom_range(0, 31)), $urandom);
  endtask

  initial begin
    int         pick;
    int         centre;
    logic [4:0] a5;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset state: all tags zero and invalid
    host_read(5'd0);
    run_ins(mem_ins(INS_LOAD, 4'd0, 8'd0));
    host_write(5'd31, 32'hFFFF_FFFF);
    host_write(5'd0, 32'h0000_0001);
    run_ins(mem_ins(INS_LOAD, 4'd0, 8'd0));
    run_ins(mem_ins(INS_LOAD, 4'd5, 8'd3));
    // address above the memory wraps to 31, window clamps at the top
    run_ins(mem_ins(INS_LOAD, 4'd1, 8'hFF));
    run_ins(mem_ins(INS_LOAD, 4'd6, 8'd28));
    run_ins(mem_ins(INS_LOAD, 4'd2, 8'd27));
    run_ins(alu_ins(INS_ADD, 4'd1, 4'd0, 4'd3));
    run_ins(alu_ins(INS_SUB, 4'd3, 4'd0, 4'd4));
    run_ins(mem_ins(INS_STORE, 4'd4, 8'd28));
    run_ins(mem_ins(INS_LOAD, 4'd7, 8'd28));
    host_write(5'd15, 32'hA5A5_5A5A);
    host_read(5'd15);
    run_ins(mem_ins(INS_LOAD, 4'd15, 8'd15));
    run_ins(alu_ins(INS_SUB, 4'd15, 4'd1, 4'd14));
    run_start();
    run_ins(alu_ins(INS_ADD, 4'd1, 4'd2, 4'd15));
    run_ins(mem_ins(INS_LOAD, 4'd9, 8'd4));
    run_ins(mem_ins(INS_STORE, 4'd15, 8'hE0));
    host_write(5'd16, 32'h0000_0000);
    host_read(5'd31);
    run_ins(mem_ins(INS_LOAD, 4'd8, 8'd16));

    centre = 16;
    for (int n = 0; n < 750; n++) begin
      steady = (n >= 300 && n < 420);
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 1)) begin
        a5 = 5'(centre + $urandom_range(0, 6) - 3);
      end else begin
        a5 = 5'($urandom_range(0, 31));
      end
      if (pick < 8) begin
        host_write(a5, $urandom);
      end else if (pick < 12) begin
        host_read(a5);
      end else if (pick < 14) begin
        run_start();
      end else if (pick < 20) begin
        run_ins(INSTR_W'($urandom_range(0, 65535)));
      end else if (pick < 55) begin
        centre = a5;
        run_ins(mem_ins(INS_LOAD, 4'($urandom_range(0, 15)),
                        {3'($urandom_range(0, 7)), a5}));
      end else if (pick < 70) begin
        run_ins(mem_ins(INS_STORE, 4'($urandom_range(0, 15)),
                        {3'($urandom_range(0, 7)), a5}));
      end else begin
        run_ins(alu_ins((pick < 85) ? INS_ADD : INS_SUB, 4'($urandom_range(0, 15)),
                        4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))));
      end
    end
    steady = 1'b0;
    s_tvalid <= 1'b0;

    // let the checker take in the last beat before watching the count
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
